### rtl/core/evs_pkg.sv
// Shared types and widths for the eddy viscosity pipeline.
// No dependencies; imported by every module of the block.
`default_nettype none

package evs_pkg;

   localparam int DIFF_W  = 32;             // velocity difference, signed Q16.16
   localparam int INV_W   = 32;             // inverse spacing, Q16.16
   localparam int COEF_W  = 40;             // model coefficient, Q8.32
   localparam int VISC_W  = 32;             // molecular viscosity, Q16.16
   localparam int DENS_W  = 32;             // density, Q16.16
   localparam int TOTAL_W = 48;             // result, Q32.16
   localparam int N_DIFF  = 9;
   localparam int N_TERM  = 6;              // three normal and three cross terms
   localparam int FRAC_W  = 16;

   localparam int RPROD_W = DIFF_W + INV_W - 1;     // |diff| * inv, top bit always zero
   localparam int RATE_W  = RPROD_W - FRAC_W;       // strain-rate magnitude
   localparam int TMAG_W  = RATE_W + 2;             // magnitude of a cross sum
   localparam int HI_W    = TMAG_W - 32;            // upper slice for partial products
   localparam int SQ_W    = 2 * TMAG_W;
   localparam int ACC_W   = SQ_W + 2;
   localparam int RAD_W   = ACC_W - 2;              // radicand of the square root
   localparam int ROOT_W  = RAD_W / 2;
   localparam int REM_W   = ROOT_W + 2;
   localparam int PC_W    = ROOT_W + COEF_W;        // |S| * coefficient
   localparam int PROD_W  = PC_W + DENS_W;          // times density
   localparam int CELL_W  = N_DIFF * DIFF_W + DENS_W;

   // First member sits in the highest bits, so du_x lands at the bottom of tdata.
   typedef struct packed {
      logic [DENS_W-1:0] cell_density;
      logic [DIFF_W-1:0] dw_y;
      logic [DIFF_W-1:0] dw_x;
      logic [DIFF_W-1:0] dv_z;
      logic [DIFF_W-1:0] dv_x;
      logic [DIFF_W-1:0] du_z;
      logic [DIFF_W-1:0] du_y;
      logic [DIFF_W-1:0] dw_z;
      logic [DIFF_W-1:0] dv_y;
      logic [DIFF_W-1:0] du_x;
   } cell_type;

   typedef struct packed {
      logic [INV_W-1:0]  inv_x;
      logic [INV_W-1:0]  inv_y;
      logic [INV_W-1:0]  inv_z;
      logic [COEF_W-1:0] coef_sq;
      logic [VISC_W-1:0] visc;
   } cfg_type;

   typedef struct packed {
      logic              valid;
      logic [RAD_W-1:0]  rad;
      logic [DENS_W-1:0] dens;
   } rad_item_type;

   typedef struct packed {
      logic              valid;
      logic [ROOT_W-1:0] root;
      logic [DENS_W-1:0] dens;
   } root_item_type;

   typedef struct packed {
      logic               valid;
      logic [TOTAL_W-1:0] total;
      logic               sat;
   } result_type;

endpackage

`default_nettype wire

### rtl/core/evs_strain.sv
// Strain-rate front end: rates, cross sums, squares and the radicand of |S|.
// Seven register stages; depends on evs_pkg.
`default_nettype none

module evs_strain
   import evs_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         en,
   input  wire logic         in_valid,
   input  wire cell_type     in_cell,
   input  wire cfg_type      cfg,
   output rad_item_type      out_item
);

   localparam int STAGES = 7;

   logic [STAGES-1:0] v_ff;
   logic [DENS_W-1:0] dens_ff [STAGES];

   // stage 1
   logic [DIFF_W-1:0]  diff_c  [N_DIFF];
   logic [INV_W-1:0]   inv_c   [N_DIFF];
   logic [DIFF_W-1:0]  mag_c   [N_DIFF];
   logic [RPROD_W-1:0] prod_in [N_DIFF];
   logic [RPROD_W-1:0] prod_ff [N_DIFF];
   logic [N_DIFF-1:0]  neg_ff;

   // stage 2
   logic [RATE_W-1:0]        nmag_ff  [3];
   logic signed [RATE_W:0]   crate_in [N_TERM];
   logic signed [RATE_W:0]   crate_ff [N_TERM];

   // stage 3
   logic signed [TMAG_W-1:0] tsum_c [3];
   logic [TMAG_W-1:0]        vmag_in [N_TERM];
   logic [TMAG_W-1:0]        vmag_ff [N_TERM];

   // stage 4
   logic [63:0]              ll_ff [N_TERM];
   logic [TMAG_W-1:0]        hl_ff [N_TERM];
   logic [2*HI_W-1:0]        hh_ff [N_TERM];

   // stage 5 to 7
   logic [SQ_W-1:0]          sq_ff [N_TERM];
   logic [ACC_W-1:0]         nsum_ff;
   logic [ACC_W-1:0]         tsum_ff;
   logic [ACC_W-1:0]         acc_in;
   logic [RAD_W-1:0]         rad_ff;

   always_comb begin
      diff_c[0] = in_cell.du_x;  inv_c[0] = cfg.inv_x;
      diff_c[1] = in_cell.dv_y;  inv_c[1] = cfg.inv_y;
      diff_c[2] = in_cell.dw_z;  inv_c[2] = cfg.inv_z;
      diff_c[3] = in_cell.du_y;  inv_c[3] = cfg.inv_y;
      diff_c[4] = in_cell.du_z;  inv_c[4] = cfg.inv_z;
      diff_c[5] = in_cell.dv_x;  inv_c[5] = cfg.inv_x;
      diff_c[6] = in_cell.dv_z;  inv_c[6] = cfg.inv_z;
      diff_c[7] = in_cell.dw_x;  inv_c[7] = cfg.inv_x;
      diff_c[8] = in_cell.dw_y;  inv_c[8] = cfg.inv_y;
      for (int i = 0; i < N_DIFF; i++) begin
         mag_c[i]   = diff_c[i][DIFF_W-1] ? (DIFF_W'(0) - diff_c[i]) : diff_c[i];
         prod_in[i] = RPROD_W'({{INV_W{1'b0}}, mag_c[i]} * {{DIFF_W{1'b0}}, inv_c[i]});
      end
   end

   // cross rates, in pairs: (3,5) (4,7) (6,8)
   always_comb begin
      for (int i = 0; i < N_TERM; i++) begin
         crate_in[i] = $signed({1'b0, prod_ff[i+3][RPROD_W-1:FRAC_W]});
         if (neg_ff[i+3]) begin
            crate_in[i] = -crate_in[i];
         end
      end
   end

   always_comb begin
      tsum_c[0] = TMAG_W'(crate_ff[0]) + TMAG_W'(crate_ff[2]);
      tsum_c[1] = TMAG_W'(crate_ff[1]) + TMAG_W'(crate_ff[4]);
      tsum_c[2] = TMAG_W'(crate_ff[3]) + TMAG_W'(crate_ff[5]);
      for (int i = 0; i < 3; i++) begin
         vmag_in[i]     = {2'b00, nmag_ff[i]};
         vmag_in[i + 3] = tsum_c[i][TMAG_W-1] ? TMAG_W'(-tsum_c[i]) : TMAG_W'(tsum_c[i]);
      end
   end

   assign acc_in = (nsum_ff << 3) + tsum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dens_ff[0] <= in_cell.cell_density;
         for (int s = 1; s < STAGES; s++) begin
            dens_ff[s] <= dens_ff[s-1];
         end
         for (int i = 0; i < N_DIFF; i++) begin
            prod_ff[i] <= prod_in[i];
            neg_ff[i]  <= diff_c[i][DIFF_W-1];
         end
         for (int i = 0; i < 3; i++) begin
            nmag_ff[i] <= prod_ff[i][RPROD_W-1:FRAC_W];
         end
         for (int i = 0; i < N_TERM; i++) begin
            crate_ff[i] <= crate_in[i];
            vmag_ff[i]  <= vmag_in[i];
            ll_ff[i]    <= {32'd0, vmag_ff[i][31:0]} * {32'd0, vmag_ff[i][31:0]};
            hl_ff[i]    <= {{(TMAG_W-HI_W){1'b0}}, vmag_ff[i][TMAG_W-1:32]} *
                           {{HI_W{1'b0}}, vmag_ff[i][31:0]};
            hh_ff[i]    <= {{HI_W{1'b0}}, vmag_ff[i][TMAG_W-1:32]} *
                           {{HI_W{1'b0}}, vmag_ff[i][TMAG_W-1:32]};
            sq_ff[i]    <= SQ_W'({hh_ff[i], 64'd0}) + SQ_W'({hl_ff[i], 33'd0}) +
                           SQ_W'(ll_ff[i]);
         end
         nsum_ff <= ACC_W'(sq_ff[0]) + ACC_W'(sq_ff[1]) + ACC_W'(sq_ff[2]);
         tsum_ff <= ACC_W'(sq_ff[3]) + ACC_W'(sq_ff[4]) + ACC_W'(sq_ff[5]);
         // drop two bits: |S|^2 is a quarter of the sum
         rad_ff  <= acc_in[ACC_W-1:2];
      end
   end

   assign out_item.valid = v_ff[STAGES-1];
   assign out_item.rad   = rad_ff;
   assign out_item.dens  = dens_ff[STAGES-1];

endmodule

`default_nettype wire

### rtl/core/evs_sqrt.sv
// Pipelined integer square root, one result bit per stage (restoring form).
// ROOT_W register stages; depends on evs_pkg.
`default_nettype none

module evs_sqrt
   import evs_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          en,
   input  wire rad_item_type  in_item,
   output root_item_type      out_item
);

   logic [ROOT_W-1:0] v_ff;
   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [RAD_W-1:0]  rad_ff  [ROOT_W];
   logic [DENS_W-1:0] dens_ff [ROOT_W];

   logic [REM_W-1:0]  rem_p   [ROOT_W];
   logic [ROOT_W-1:0] root_p  [ROOT_W];
   logic [RAD_W-1:0]  rad_p   [ROOT_W];
   logic [DENS_W-1:0] dens_p  [ROOT_W];
   logic [REM_W-1:0]  shift_c [ROOT_W];
   logic [REM_W-1:0]  trial_c [ROOT_W];
   logic [REM_W-1:0]  rem_in  [ROOT_W];
   logic [ROOT_W-1:0] root_in [ROOT_W];

   always_comb begin
      rem_p[0]  = '0;
      root_p[0] = '0;
      rad_p[0]  = in_item.rad;
      dens_p[0] = in_item.dens;
      for (int k = 1; k < ROOT_W; k++) begin
         rem_p[k]  = rem_ff[k-1];
         root_p[k] = root_ff[k-1];
         rad_p[k]  = rad_ff[k-1];
         dens_p[k] = dens_ff[k-1];
      end
      for (int k = 0; k < ROOT_W; k++) begin
         // bring down the next two radicand bits, try root*4+1
         shift_c[k] = {rem_p[k][REM_W-3:0], rad_p[k][RAD_W-1:RAD_W-2]};
         trial_c[k] = {root_p[k], 2'b01};
         if (shift_c[k] >= trial_c[k]) begin
            rem_in[k]  = shift_c[k] - trial_c[k];
            root_in[k] = {root_p[k][ROOT_W-2:0], 1'b1};
         end else begin
            rem_in[k]  = shift_c[k];
            root_in[k] = {root_p[k][ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[ROOT_W-2:0], in_item.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < ROOT_W; k++) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            rad_ff[k]  <= {rad_p[k][RAD_W-3:0], 2'b00};
            dens_ff[k] <= dens_p[k];
         end
      end
   end

   assign out_item.valid = v_ff[ROOT_W-1];
   assign out_item.root  = root_ff[ROOT_W-1];
   assign out_item.dens  = dens_ff[ROOT_W-1];

endmodule

`default_nettype wire

### rtl/core/evs_scale.sv
// Scaling back end: |S| * coefficient * density, plus molecular viscosity,
// with saturation. Five register stages; depends on evs_pkg.
`default_nettype none

module evs_scale
   import evs_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           en,
   input  wire root_item_type  in_item,
   input  wire cfg_type        cfg,
   output result_type          out_item
);

   localparam int STAGES = 5;
   localparam int RH_W   = ROOT_W - 32;
   localparam int CH_W   = COEF_W - 32;
   localparam int AH_W   = PC_W - 64;

   logic [STAGES-1:0]       v_ff;
   logic [DENS_W-1:0]       densa_ff;
   logic [DENS_W-1:0]       densb_ff;

   logic [63:0]             p0_ff;
   logic [31+CH_W:0]        p1_ff;
   logic [31+RH_W:0]        p2_ff;
   logic [RH_W+CH_W-1:0]    p3_ff;
   logic [PC_W-1:0]         pc_ff;
   logic [63:0]             q0_ff;
   logic [63:0]             q1_ff;
   logic [AH_W+DENS_W-1:0]  q2_ff;
   logic [PROD_W-1:0]       prod_ff;
   logic [TOTAL_W-1:0]      total_ff;
   logic                    sat_ff;

   logic [TOTAL_W:0]        sum_c;
   logic                    sat_c;

   assign sum_c = {1'b0, prod_ff[TOTAL_W+47:48]} + (TOTAL_W+1)'(cfg.visc);
   assign sat_c = (|prod_ff[PROD_W-1:TOTAL_W+48]) | sum_c[TOTAL_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[STAGES-2:0], in_item.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         densa_ff <= in_item.dens;
         densb_ff <= densa_ff;
         p0_ff    <= {32'd0, in_item.root[31:0]} * {32'd0, cfg.coef_sq[31:0]};
         p1_ff    <= {{CH_W{1'b0}}, in_item.root[31:0]} *
                     {32'd0, cfg.coef_sq[COEF_W-1:32]};
         p2_ff    <= {32'd0, in_item.root[ROOT_W-1:32]} *
                     {{RH_W{1'b0}}, cfg.coef_sq[31:0]};
         p3_ff    <= {{CH_W{1'b0}}, in_item.root[ROOT_W-1:32]} *
                     {{RH_W{1'b0}}, cfg.coef_sq[COEF_W-1:32]};
         pc_ff    <= PC_W'(p0_ff) + PC_W'({p1_ff, 32'd0}) + PC_W'({p2_ff, 32'd0}) +
                     PC_W'({p3_ff, 64'd0});
         q0_ff    <= {32'd0, pc_ff[31:0]} * {32'd0, densb_ff};
         q1_ff    <= {32'd0, pc_ff[63:32]} * {32'd0, densb_ff};
         q2_ff    <= {{DENS_W{1'b0}}, pc_ff[PC_W-1:64]} * {{AH_W{1'b0}}, densb_ff};
         prod_ff  <= PROD_W'(q0_ff) + PROD_W'({q1_ff, 32'd0}) + PROD_W'({q2_ff, 64'd0});
         // clip to all ones when the eddy term or the sum overflows
         sat_ff   <= sat_c;
         total_ff <= sat_c ? {TOTAL_W{1'b1}} : sum_c[TOTAL_W-1:0];
      end
   end

   assign out_item.valid = v_ff[STAGES-1];
   assign out_item.total = total_ff;
   assign out_item.sat   = sat_ff;

endmodule

`default_nettype wire

### rtl/core/evs_out_buf.sv
// Output register with a one-entry skid stage; drives the pipeline enable.
// Depends on evs_pkg.
`default_nettype none

module evs_out_buf
   import evs_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire result_type    tail,
   input  wire logic          out_ready,
   output logic               en,
   output logic               out_valid,
   output logic [TOTAL_W-1:0] out_total,
   output logic               out_sat
);

   logic               out_valid_ff, out_valid_in;
   logic               skid_full_ff, skid_full_in;
   logic               load_out, load_skid, move_skid;
   logic [TOTAL_W-1:0] out_total_ff, skid_total_ff;
   logic               out_sat_ff, skid_sat_ff;
   logic               take;
   logic               push;

   assign en   = !skid_full_ff;
   assign take = out_valid_ff && out_ready;
   assign push = en && tail.valid;

   always_comb begin
      out_valid_in = out_valid_ff;
      skid_full_in = skid_full_ff;
      load_out     = 1'b0;
      load_skid    = 1'b0;
      move_skid    = 1'b0;
      if (skid_full_ff) begin
         if (take) begin
            move_skid    = 1'b1;
            skid_full_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || take) begin
            load_out     = 1'b1;
            out_valid_in = 1'b1;
         end else begin
            // hold the waiting result, park the new one
            load_skid    = 1'b1;
            skid_full_in = 1'b1;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         skid_full_ff <= skid_full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_total_ff <= tail.total;
         out_sat_ff   <= tail.sat;
      end else if (move_skid) begin
         out_total_ff <= skid_total_ff;
         out_sat_ff   <= skid_sat_ff;
      end
      if (load_skid) begin
         skid_total_ff <= tail.total;
         skid_sat_ff   <= tail.sat;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_total = out_total_ff;
   assign out_sat   = out_sat_ff;

endmodule

`default_nettype wire

### rtl/core/eddy_viscosity_from_strain_rate.sv
// Top level of the eddy viscosity pipeline: configuration registers and the
// chain evs_strain, evs_sqrt, evs_scale, evs_out_buf; depends on evs_pkg.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_tvalid/tready  | req_tdata: nine differences, density
//   rsp     | out       | rsp_tvalid/tready  | rsp_tdata: total_visc; rsp_tuser: saturated
//   csr     | in        | csr_we             | csr_index, csr_wdata
//
// One cell per cycle while the skid stage is empty; 62 register stages (7 strain stages,
// 49 square-root stages of one root bit each, 5 scaling stages, 1 output register).
// Reset clears all valid bits and loads register defaults.
// A stalled result parks one follower in a skid stage; the whole pipeline then
// holds until the skid stage drains, so nothing is lost or repeated.
`default_nettype none

module eddy_viscosity_from_strain_rate
   import evs_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   // du_x, dv_y, dw_z, du_y, du_z, dv_x, dv_z, dw_x, dw_y, cell_density (32 each)
   input  wire logic [CELL_W-1:0]  req_tdata,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   // total_visc (48)
   output logic [TOTAL_W-1:0]      rsp_tdata,
   // saturated (1)
   output logic [0:0]              rsp_tuser,
   input  wire logic               csr_we,
   input  wire logic [2:0]         csr_index,
   input  wire logic [COEF_W-1:0]  csr_wdata
);

   localparam logic [2:0] CSR_INV_X = 3'd0;
   localparam logic [2:0] CSR_INV_Y = 3'd1;
   localparam logic [2:0] CSR_INV_Z = 3'd2;
   localparam logic [2:0] CSR_COEF  = 3'd3;
   localparam logic [2:0] CSR_VISC  = 3'd4;
   localparam logic [INV_W-1:0] INV_ONE = INV_W'(1) << FRAC_W;

   cfg_type       cfg_ff;
   cell_type      req_cell;
   logic          en;
   logic          sat_out;
   rad_item_type  rad_item;
   root_item_type root_item;
   result_type    tail;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.inv_x   <= INV_ONE;
         cfg_ff.inv_y   <= INV_ONE;
         cfg_ff.inv_z   <= INV_ONE;
         cfg_ff.coef_sq <= '0;
         cfg_ff.visc    <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_INV_X: cfg_ff.inv_x   <= csr_wdata[INV_W-1:0];
            CSR_INV_Y: cfg_ff.inv_y   <= csr_wdata[INV_W-1:0];
            CSR_INV_Z: cfg_ff.inv_z   <= csr_wdata[INV_W-1:0];
            CSR_COEF:  cfg_ff.coef_sq <= csr_wdata;
            CSR_VISC:  cfg_ff.visc    <= csr_wdata[VISC_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_cell   = cell_type'(req_tdata);
   assign req_tready = en;
   assign rsp_tuser  = sat_out;

   evs_strain u_strain (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_tvalid),
      .in_cell  (req_cell),
      .cfg      (cfg_ff),
      .out_item (rad_item)
   );

   evs_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_item  (rad_item),
      .out_item (root_item)
   );

   evs_scale u_scale (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_item  (root_item),
      .cfg      (cfg_ff),
      .out_item (tail)
   );

   evs_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .tail      (tail),
      .out_ready (rsp_tready),
      .en        (en),
      .out_valid (rsp_tvalid),
      .out_total (rsp_tdata),
      .out_sat   (sat_out)
   );

endmodule

`default_nettype wire

### tb/evs_tb_pkg.sv
// Register map of the eddy viscosity block's configuration port, as seen by the testbench.
// No dependencies; imported by the checker and the testbench top.
package evs_tb_pkg;

   typedef enum logic [2:0] {
      CSR_INV_X    = 3'd0,
      CSR_INV_Y    = 3'd1,
      CSR_INV_Z    = 3'd2,
      CSR_COEF_SQ  = 3'd3,
      CSR_MOL_VISC = 3'd4
   } csr_reg_type;

   localparam int CSR_REG_COUNT = 5;

endpackage

### tb/evs_checker.sv
// Scoreboard for the eddy viscosity block: mirrors the configuration registers, predicts
// total viscosity and the saturation flag per accepted cell, compares results in order.
// Depends on evs_pkg and evs_tb_pkg.
module evs_checker
   import evs_pkg::*;
   import evs_tb_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   input  wire logic              req_tready,
   input  wire logic [CELL_W-1:0] req_tdata,
   input  wire logic              rsp_tvalid,
   input  wire logic              rsp_tready,
   input  wire logic [TOTAL_W-1:0] rsp_tdata,
   input  wire logic [0:0]        rsp_tuser,
   input  wire logic              csr_we,
   input  wire logic [2:0]        csr_index,
   input  wire logic [COEF_W-1:0] csr_wdata,
   output int                     mismatch_count,
   output int                     results_checked,
   output int                     in_flight
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [TOTAL_W-1:0] total;
      logic               sat;
   } visc_result_type;

   localparam logic [TOTAL_W-1:0] VISC_MAX = '1;

   logic [INV_W-1:0]  inv_x, inv_y, inv_z;
   logic [COEF_W-1:0] coef_sq;
   logic [VISC_W-1:0] mol_visc;
   visc_result_type   expected_visc_q[$];

   // difference times inverse spacing, 16 fraction bits dropped from the magnitude
   function automatic logic signed [63:0] strain_rate(input logic [DIFF_W-1:0] diff,
                                                      input logic [INV_W-1:0] inv);
      logic [63:0] mag_d;
      logic [63:0] scaled;
      mag_d  = diff[DIFF_W-1] ? {32'd0, ~diff + 32'd1} : {32'd0, diff};
      scaled = (mag_d * {32'd0, inv}) >> FRAC_W;
      return diff[DIFF_W-1] ? -$signed(scaled) : $signed(scaled);
   endfunction

   function automatic logic [127:0] square_mag(input logic signed [63:0] v);
      logic [63:0] m;
      m = v[63] ? ~v + 64'd1 : v;
      return {64'd0, m} * {64'd0, m};
   endfunction

   function automatic logic [63:0] floor_sqrt(input logic [127:0] q);
      logic [63:0] root;
      logic [63:0] cand;
      root = '0;
      for (int b = 63; b >= 0; b--) begin
         cand = root | (64'd1 << b);
         if ({64'd0, cand} * {64'd0, cand} <= q) root = cand;
      end
      return root;
   endfunction

   function automatic visc_result_type predict_visc(input cell_type c);
      logic signed [63:0] s11, s22, s33, t12, t13, t23;
      logic [127:0]       acc, prod, eddy;
      logic [TOTAL_W:0]   sum;
      visc_result_type    r;
      s11 = strain_rate(c.du_x, inv_x);
      s22 = strain_rate(c.dv_y, inv_y);
      s33 = strain_rate(c.dw_z, inv_z);
      t12 = strain_rate(c.du_y, inv_y) + strain_rate(c.dv_x, inv_x);
      t13 = strain_rate(c.du_z, inv_z) + strain_rate(c.dw_x, inv_x);
      t23 = strain_rate(c.dv_z, inv_z) + strain_rate(c.dw_y, inv_y);
      // 8*(normal squares) + cross-sum squares, then quarter it for |S|^2
      acc = ((square_mag(s11) + square_mag(s22) + square_mag(s33)) << 3)
            + square_mag(t12) + square_mag(t13) + square_mag(t23);
      prod = {64'd0, floor_sqrt(acc >> 2)} * {88'd0, coef_sq} * {96'd0, c.cell_density};
      eddy = prod >> 48;
      if (eddy > {80'd0, VISC_MAX}) begin
         r.total = VISC_MAX;
         r.sat   = 1'b1;
      end else begin
         sum = {1'b0, eddy[TOTAL_W-1:0]} + {17'd0, mol_visc};
         r.sat   = sum[TOTAL_W];
         r.total = sum[TOTAL_W] ? VISC_MAX : sum[TOTAL_W-1:0];
      end
      return r;
   endfunction

   always @(posedge clock) begin : monitor
      visc_result_type want;
      if (reset) begin
         inv_x           = 32'h0001_0000;
         inv_y           = 32'h0001_0000;
         inv_z           = 32'h0001_0000;
         coef_sq         = '0;
         mol_visc        = '0;
         mismatch_count  = 0;
         results_checked = 0;
         expected_visc_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_INV_X:    inv_x    = csr_wdata[INV_W-1:0];
               CSR_INV_Y:    inv_y    = csr_wdata[INV_W-1:0];
               CSR_INV_Z:    inv_z    = csr_wdata[INV_W-1:0];
               CSR_COEF_SQ:  coef_sq  = csr_wdata;
               CSR_MOL_VISC: mol_visc = csr_wdata[VISC_W-1:0];
               default: ;    // unmapped index: drop the write
            endcase
         end
         if (req_tvalid && req_tready)
            expected_visc_q.push_back(predict_visc(cell_type'(req_tdata)));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_visc_q.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected result transaction: total_visc=%h saturated=%b",
                           rsp_tdata, rsp_tuser[0]);
               mismatch_count++;
            end else begin
               want = expected_visc_q.pop_front();
               if (rsp_tdata !== want.total || rsp_tuser[0] !== want.sat) begin
                  if (mismatch_count < 10)
                     $display({"result %0d mismatch: total_visc exp %h got %h,",
                               " saturated exp %b got %b"}, results_checked,
                              want.total, rsp_tdata, want.sat, rsp_tuser[0]);
                  mismatch_count++;
               end
               results_checked++;
            end
         end
      end
      in_flight = expected_visc_q.size();
   end

endmodule

### tb/eddy_viscosity_from_strain_rate_tb.sv
// Testbench top for eddy_viscosity_from_strain_rate: drives cells and register writes,
// stalls the result side at random and gives the verdict; evs_checker does the checking.
// Depends on evs_pkg, evs_tb_pkg and evs_checker.
module eddy_viscosity_from_strain_rate_tb
   import evs_pkg::*, evs_tb_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          LATENCY     = 62;
   localparam int          PHASE_ITEMS = 275;
   localparam int          RAND_PHASES = 6;
   localparam int unsigned CYCLE_LIMIT = 400000;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_tvalid;
   logic               req_tready;
   logic [CELL_W-1:0]  req_tdata;
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic [TOTAL_W-1:0] rsp_tdata;
   logic [0:0]         rsp_tuser;
   logic               csr_we;
   logic [2:0]         csr_index;
   logic [COEF_W-1:0]  csr_wdata;

   int          mismatch_count;
   int          results_checked;
   int          in_flight;
   int          cells_sent = 0;
   int          phase_count = 0;
   bit          send_burst = 1'b0;
   bit          recv_burst = 1'b0;
   int unsigned cycle_count = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   eddy_viscosity_from_strain_rate DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   evs_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .results_checked (results_checked),
      .in_flight       (in_flight)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count, in_flight);
         $display("== FAIL ==");
         $finish;
      end
   end

   // result side: unless in burst mode, stall a random number of cycles, then hold ready until one transaction
   initial begin : result_sink
      int stall;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = recv_burst ? 0 : $urandom_range(0, 16);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [COEF_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_cell(input cell_type c);
      int gap;
      gap = send_burst ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      do @(posedge clock); while (!req_tready);
      cells_sent++;
   endtask

   // drop valid, wait for every expected result, then let the pipeline settle
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (in_flight != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
      phase_count++;
   endtask

   function automatic cell_type uniform_cell(input logic [DIFF_W-1:0] d,
                                             input logic [DENS_W-1:0] dens);
      cell_type c;
      c = '{cell_density: dens, default: d};
      return c;
   endfunction

   function automatic logic [DIFF_W-1:0] random_diff();
      logic [DIFF_W-1:0] v;
      int                w;
      case ($urandom_range(0, 9))
         0, 1: v = $urandom;
         2: begin
            case ($urandom_range(0, 3))
               0:       v = 32'h8000_0000;
               1:       v = 32'h7FFF_FFFF;
               2:       v = 32'hFFFF_FFFF;
               default: v = 32'h0000_0000;
            endcase
         end
         default: begin
            w = $urandom_range(1, 24);
            v = $urandom & ((32'd1 << w) - 32'd1);
            if ($urandom_range(0, 1)) v = -v;
         end
      endcase
      return v;
   endfunction

   function automatic logic [DENS_W-1:0] random_density();
      case ($urandom_range(0, 5))
         0:       return $urandom;
         1:       return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
         default: return $urandom_range(0, 32'h0004_0000);
      endcase
   endfunction

   function automatic logic [COEF_W-1:0] random_reg_value(input csr_reg_type r,
                                                          input int mode);
      logic [7:0] top;
      top = 8'($urandom_range(0, 255));
      case (mode)
         0: begin
            // spacings near unity and a modest coefficient keep most results unclipped
            case (r) inside
               CSR_INV_X, CSR_INV_Y, CSR_INV_Z:
                  return 40'($urandom_range(32'h0000_1000, 32'h0010_0000));
               CSR_COEF_SQ: return {8'd0, 32'($urandom)};
               default:     return 40'($urandom_range(0, 32'h0010_0000));
            endcase
         end
         1: return {top, 32'($urandom)};
         default: begin
            case ($urandom_range(0, 2))
               0:       return '0;
               1:       return '1;
               default: return 40'd1;
            endcase
         end
      endcase
   endfunction

   initial begin : stimulus
      cell_type c;
      int       mode;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_index  <= CSR_INV_X;
      csr_wdata  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register defaults: coefficient zero, so everything reduces to zero viscosity
      send_burst = 1'b1;
      send_cell(uniform_cell(32'h0000_0000, 32'h0000_0000));
      send_cell(uniform_cell(32'h7FFF_FFFF, 32'hFFFF_FFFF));
      send_cell(uniform_cell(32'h8000_0000, 32'hFFFF_FFFF));
      drain();

      // |S| = 2^30 exactly; eddy + viscosity lands on the 48-bit limit without clipping
      send_burst = 1'b0;
      write_reg(CSR_INV_X, 40'h00_0001_0000);
      write_reg(CSR_INV_Y, 40'h00_0001_0000);
      write_reg(CSR_INV_Z, 40'h00_0001_0000);
      write_reg(CSR_COEF_SQ, 40'hFF_FF00_0000);
      write_reg(CSR_MOL_VISC, 40'h00_FFFF_FFFF);
      c = '0;
      c.du_y = 32'h4000_0000;
      c.dv_x = 32'h4000_0000;
      c.cell_density = 32'h0400_0000;
      send_cell(c);
      c.du_y = 32'h4000_0002;             // one step over: clips on the add
      send_cell(c);
      c.du_y = 32'hC000_0000;
      c.dv_x = 32'hC000_0000;
      send_cell(c);
      c.cell_density = '0;
      send_cell(c);
      drain();

      // every register at its maximum; extreme, zero, unit and cancelling cells
      recv_burst = 1'b1;
      write_reg(CSR_INV_X, 40'h00_FFFF_FFFF);
      write_reg(CSR_INV_Y, 40'h00_FFFF_FFFF);
      write_reg(CSR_INV_Z, 40'h00_FFFF_FFFF);
      write_reg(CSR_COEF_SQ, 40'hFF_FFFF_FFFF);
      write_reg(CSR_MOL_VISC, 40'h00_FFFF_FFFF);
      send_cell(uniform_cell(32'h7FFF_FFFF, 32'hFFFF_FFFF));
      send_cell(uniform_cell(32'h8000_0000, 32'hFFFF_FFFF));
      send_cell(uniform_cell(32'h0000_0000, 32'hFFFF_FFFF));
      send_cell(uniform_cell(32'h0000_0001, 32'h0000_0001));
      c = '0;
      c.du_y = 32'h7FFF_FFFF;             // cross pair cancels
      c.dv_x = 32'h8000_0001;
      c.cell_density = 32'hFFFF_FFFF;
      send_cell(c);
      drain();

      // upper data bits masked off, x spacing zero, unmapped indexes ignored
      recv_burst = 1'b0;
      write_reg(CSR_INV_X, 40'hFF_0000_0000);
      write_reg(CSR_INV_Y, 40'h01_0000_0001);
      write_reg(CSR_INV_Z, 40'hAB_0001_0000);
      write_reg(CSR_COEF_SQ, 40'h01_0000_0000);
      write_reg(CSR_MOL_VISC, 40'hFF_0000_1000);
      for (int k = CSR_REG_COUNT; k < 8; k++) write_reg(3'(k), 40'hFF_FFFF_FFFF);
      send_cell(uniform_cell(32'h7FFF_FFFF, 32'h0001_0000));
      c = '0;
      c.du_x = 32'h7FFF_FFFF;
      c.dv_x = 32'h8000_0000;
      c.dw_x = 32'h7FFF_FFFF;
      c.cell_density = 32'hFFFF_FFFF;
      send_cell(c);
      send_cell(uniform_cell(32'h8000_0000, 32'hFFFF_FFFF));
      send_cell(uniform_cell(32'h0012_3456, 32'h0002_0000));
      drain();

      for (int p = 0; p < RAND_PHASES; p++) begin
         // first phase sticks to realistic settings, later ones mix in wide and extreme
         mode = (p == 0) ? 0 : $urandom_range(0, 2);
         send_burst = ($urandom_range(0, 3) == 0);
         recv_burst = ($urandom_range(0, 3) == 0);
         for (int r = 0; r < CSR_REG_COUNT; r++)
            write_reg(3'(r), random_reg_value(csr_reg_type'(r), mode));
         if ($urandom_range(0, 1))
            write_reg(3'($urandom_range(CSR_REG_COUNT, 7)), 40'($urandom));
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            c.du_x = random_diff();
            c.dv_y = random_diff();
            c.dw_z = random_diff();
            c.du_y = random_diff();
            c.du_z = random_diff();
            c.dv_x = random_diff();
            c.dv_z = random_diff();
            c.dw_x = random_diff();
            c.dw_y = random_diff();
            c.cell_density = random_density();
            send_cell(c);
         end
         drain();
      end

      $display("sent %0d cells over %0d register settings, %0d results checked",
               cells_sent, phase_count, results_checked);
      $display("covered defaults, exact and clipped limits, zero and masked spacings");
      if (mismatch_count == 0 && in_flight == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches, %0d results outstanding", mismatch_count, in_flight);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
